### rtl/core/bsc_pkg.sv
// Package for the broadcast suppression cache core.
// Holds the command and status codes, entry record and cell control types.
// Used by bsc_cell and broadcast_suppression_cache_core.
package bsc_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    CMD_RECEIVE   = 2'd0,
    CMD_ORIGINATE = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_EXPIRE    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_NEW       = 4'd0,
    ST_DUP_ORIG  = 4'd1,
    ST_OVERHEARD = 4'd2,
    ST_DECIDED   = 4'd3,
    ST_FULL      = 4'd4,
    ST_ORIGINATE = 4'd5,
    ST_DECISION  = 4'd6,
    ST_TICK_DONE = 4'd7,
    ST_EXPIRED   = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    REG_LIFETIME  = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_MAX_READY = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] source;
    logic [15:0] sequence_no;
    logic [31:0] touched;
    logic [31:0] deadline;
    logic [7:0]  overheard;
    logic        decided;
    logic        transmit;
    logic        local_dest;
  } entry_t;

  // write into one cell: slot selects it, op says what to do
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TOUCH,
    OP_COUNT,
    OP_ALLOC,
    OP_DECIDE,
    OP_KILL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [SLOT_W-1:0] slot;
    entry_t      data;
  } cell_wr_t;

endpackage

### rtl/core/bsc_cell.sv
// One cache cell of the broadcast suppression cache.
// Holds one entry and hands it down the rotating ring each scan cycle.
// Depends on bsc_pkg.
module bsc_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  bsc_pkg::entry_t     prev_entry,
  input  logic                wr_en,
  input  bsc_pkg::entry_t     wr_data,
  output bsc_pkg::entry_t     entry
);

  bsc_pkg::entry_t entry_next;

  always_comb begin
    entry_next = entry;
    if (shift) begin
      entry_next = prev_entry;
    end else if (wr_en) begin
      entry_next = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.source      <= entry_next.source;
    entry.sequence_no <= entry_next.sequence_no;
    entry.touched     <= entry_next.touched;
    entry.deadline    <= entry_next.deadline;
    entry.overheard   <= entry_next.overheard;
    entry.decided     <= entry_next.decided;
    entry.transmit    <= entry_next.transmit;
    entry.local_dest  <= entry_next.local_dest;
  end

endmodule

### rtl/core/broadcast_suppression_cache_core.sv
// Broadcast suppression cache core: 16 entry duplicate-suppression cache.
// Each command rotates the ring of cells once, examining the entry in
// cell 0 each cycle, and then registers its result. One command at a time.
// Reset clears all valid bits and sets the configuration registers to their
// defaults.
module broadcast_suppression_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] id_source,
  input  logic [15:0] id_sequence,
  input  logic [15:0] prev_hop,
  input  logic        local_destination,
  input  logic [31:0] backoff_deadline,
  input  logic [31:0] now_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [3:0]  slot,
  output logic [7:0]  overheard_count,
  output logic [15:0] out_source,
  output logic [15:0] out_sequence,
  output logic        transmit,
  output logic [4:0]  item_count,
  output logic        last
);

  localparam int N  = bsc_pkg::ENTRIES;
  localparam int SW = bsc_pkg::SLOT_W;
  localparam int CW = bsc_pkg::CNT_W;

  logic [31:0] lifetime;
  logic [7:0]  threshold;
  logic [4:0]  max_ready;

  bsc_pkg::state_t state, state_next;

  bsc_pkg::cmd_t c_cmd;
  logic [15:0] c_src, c_seq, c_prev;
  logic        c_local;
  logic [31:0] c_bdl, c_now;

  logic [SW-1:0] pos;
  logic          match_hit, free_hit;
  logic [SW-1:0] match_slot, free_slot;
  logic [CW-1:0] count;
  logic [N-1:0]  ready;

  bsc_pkg::entry_t cells [N];
  bsc_pkg::entry_t wr_data;
  bsc_pkg::entry_t tail_in;
  logic            shift;
  bsc_pkg::cell_wr_t wr;

  // ring: cell i takes from cell i+1, cell N-1 from cell 0
  for (genvar g = 0; g < N; g++) begin : g_cell
    bsc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (shift),
      .prev_entry ((g == N - 1) ? tail_in : cells[(g + 1) % N]),
      .wr_en      (wr.op != bsc_pkg::OP_NONE && wr.slot == SW'(g)),
      .wr_data    (wr.data),
      .entry      (cells[g])
    );
  end

  bsc_pkg::entry_t head;
  logic head_live, head_match, head_ready, limit_ok;
  logic [4:0] limit;
  assign head       = cells[0];
  assign head_live  = head.valid && ((c_now - head.touched) < lifetime);
  assign head_match = head_live && head.source == c_src && head.sequence_no == c_seq;
  assign head_ready = head.valid && !head.decided && !head.local_dest &&
                      (c_now >= head.deadline);
  assign limit      = (max_ready > 5'(N)) ? 5'(N) : max_ready;

  // drop aged entries as they leave the head during a sweep
  always_comb begin
    tail_in = head;
    if (c_cmd == bsc_pkg::CMD_EXPIRE && !head_live) begin
      tail_in.valid = 1'b0;
    end
  end

  logic [SW-1:0] first_ready;
  logic          any_ready;
  always_comb begin
    first_ready = '0;
    any_ready   = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (ready[i]) begin
        first_ready = SW'(i);
        any_ready   = 1'b1;
      end
    end
  end
  assign limit_ok = 5'(count) < limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime  <= 32'd30000;
      threshold <= 8'd2;
      max_ready <= 5'd16;
    end else if (cfg_we) begin
      case (bsc_pkg::reg_idx_t'(cfg_index))
        bsc_pkg::REG_LIFETIME:  lifetime  <= cfg_data;
        bsc_pkg::REG_THRESHOLD: threshold <= cfg_data[7:0];
        bsc_pkg::REG_MAX_READY: max_ready <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic in_xfer, out_xfer;
  assign in_stall = (state != bsc_pkg::S_IDLE) || out_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // result selection after the scan
  bsc_pkg::entry_t r_ent;
  logic orig;
  assign orig  = c_prev == c_src;
  assign r_ent = cells[match_hit ? match_slot : free_slot];

  always_comb begin
    state_next = state;
    shift      = 1'b0;
    wr         = '{op: bsc_pkg::OP_NONE, slot: '0, data: '0};
    wr_data    = r_ent;
    case (state)
      bsc_pkg::S_IDLE: begin
        if (in_xfer) state_next = bsc_pkg::S_SCAN;
      end
      bsc_pkg::S_SCAN: begin
        shift = 1'b1;
        if (pos == SW'(N - 1)) begin
          state_next = (c_cmd == bsc_pkg::CMD_TICK) ? bsc_pkg::S_DECIDE : bsc_pkg::S_RESULT;
        end
      end
      bsc_pkg::S_RESULT: begin
        if (!out_valid) state_next = bsc_pkg::S_IDLE;
        if (!out_valid) begin
          case (c_cmd)
            bsc_pkg::CMD_RECEIVE: begin
              wr_data.touched = c_now;
              if (match_hit) begin
                wr.slot = match_slot;
                if (!orig && r_ent.overheard != 8'hFF) begin
                  wr_data.overheard = r_ent.overheard + 8'd1;
                end
                wr.op = bsc_pkg::OP_TOUCH;
              end else if (free_hit) begin
                wr.slot = free_slot;
                wr.op   = bsc_pkg::OP_ALLOC;
                wr_data = '{valid: 1'b1, source: c_src, sequence_no: c_seq,
                            touched: c_now, deadline: c_local ? c_now : c_bdl,
                            overheard: orig ? 8'd0 : 8'd1, decided: c_local,
                            transmit: 1'b0, local_dest: c_local};
              end
            end
            bsc_pkg::CMD_ORIGINATE: begin
              if (free_hit) begin
                wr.slot = free_slot;
                wr.op   = bsc_pkg::OP_ALLOC;
                wr_data = '{valid: 1'b1, source: c_src, sequence_no: c_seq,
                            touched: c_now, deadline: c_now, overheard: 8'd0,
                            decided: 1'b1, transmit: 1'b1, local_dest: 1'b0};
              end
            end
            default: ;
          endcase
        end
      end
      bsc_pkg::S_DECIDE: begin
        if (!out_valid) begin
          if (any_ready && limit_ok) begin
            wr.slot = first_ready;
            wr.op   = bsc_pkg::OP_DECIDE;
            wr_data = cells[first_ready];
            wr_data.decided  = 1'b1;
            wr_data.transmit = cells[first_ready].overheard < threshold;
            wr_data.touched  = c_now;
          end else begin
            state_next = bsc_pkg::S_IDLE;
          end
        end
      end
      default: state_next = bsc_pkg::S_IDLE;
    endcase
    wr.data = wr_data;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      c_cmd   <= bsc_pkg::cmd_t'(cmd);
      c_src   <= id_source;
      c_seq   <= id_sequence;
      c_prev  <= prev_hop;
      c_local <= local_destination;
      c_bdl   <= backoff_deadline;
      c_now   <= now_ms;
    end
  end

  // scan bookkeeping; pos is the original slot of the entry at the head
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pos       <= '0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      count     <= '0;
      ready     <= '0;
    end else if (state == bsc_pkg::S_SCAN) begin
      pos <= pos + SW'(1);
      if (head_match && !match_hit) begin
        match_hit  <= 1'b1;
        match_slot <= pos;
      end
      if (!head_live && !free_hit) begin
        free_hit  <= 1'b1;
        free_slot <= pos;
      end
      ready[pos] <= head_ready;
      if (c_cmd == bsc_pkg::CMD_EXPIRE && head.valid && !head_live) begin
        count <= count + CW'(1);
      end
    end else if (state == bsc_pkg::S_DECIDE && !out_valid && any_ready && limit_ok) begin
      ready[first_ready] <= 1'b0;
      count <= count + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end else if (!out_valid && (state == bsc_pkg::S_RESULT ||
                 state == bsc_pkg::S_DECIDE)) begin
      out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid) begin
      status          <= 4'(bsc_pkg::ST_TICK_DONE);
      slot            <= '0;
      overheard_count <= '0;
      out_source      <= c_src;
      out_sequence    <= c_seq;
      transmit        <= 1'b0;
      item_count      <= '0;
      last            <= 1'b1;
      if (state == bsc_pkg::S_DECIDE) begin
        out_source   <= '0;
        out_sequence <= '0;
        if (any_ready && limit_ok) begin
          status          <= 4'(bsc_pkg::ST_DECISION);
          slot            <= 4'(first_ready);
          overheard_count <= cells[first_ready].overheard;
          out_source      <= cells[first_ready].source;
          out_sequence    <= cells[first_ready].sequence_no;
          transmit        <= cells[first_ready].overheard < threshold;
          last            <= 1'b0;
        end else begin
          item_count <= 5'(count);
        end
      end else begin
        case (c_cmd)
          bsc_pkg::CMD_RECEIVE: begin
            if (match_hit) begin
              slot <= 4'(match_slot);
              if (orig) begin
                status          <= 4'(bsc_pkg::ST_DUP_ORIG);
                overheard_count <= r_ent.overheard;
              end else begin
                status <= r_ent.decided ? 4'(bsc_pkg::ST_DECIDED) :
                                          4'(bsc_pkg::ST_OVERHEARD);
                overheard_count <= (r_ent.overheard == 8'hFF) ? 8'hFF :
                                   r_ent.overheard + 8'd1;
              end
            end else if (free_hit) begin
              status          <= 4'(bsc_pkg::ST_NEW);
              slot            <= 4'(free_slot);
              overheard_count <= orig ? 8'd0 : 8'd1;
            end else begin
              status <= 4'(bsc_pkg::ST_FULL);
            end
          end
          bsc_pkg::CMD_ORIGINATE: begin
            if (free_hit) begin
              status <= 4'(bsc_pkg::ST_ORIGINATE);
              slot   <= 4'(free_slot);
            end else begin
              status <= 4'(bsc_pkg::ST_FULL);
            end
          end
          default: begin
            status       <= 4'(bsc_pkg::ST_EXPIRED);
            out_source   <= '0;
            out_sequence <= '0;
            item_count   <= 5'(count);
          end
        endcase
      end
    end
  end

endmodule
